### hdl/ngp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ngp_pkg
// Types and codes shared by the equal-size group partition stepper.
// ----------------------------------------------------------------------------
package ngp_pkg;

  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_IDENT = 2'd1;
  localparam logic [1:0] ACT_ADV   = 2'd2;

  localparam logic [1:0] CFG_GSIZE  = 2'd0;
  localparam logic [1:0] CFG_GCOUNT = 2'd1;

  localparam int unsigned STORE = 32;

  // signed index wide enough for every walk pointer
  typedef logic signed [7:0] sidx_t;

  typedef struct packed {
    logic [1:0] action;
    logic [4:0] position;
    logic [4:0] value;
  } cmd_t;

  typedef struct packed {
    logic [4:0] slot;
    logic [4:0] label;
    logic       last;
    logic       has_next;
  } res_t;

endpackage

### hdl/next_equal_group_partition_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// next_equal_group_partition_top
// Load, identity order or advance to the next equal-size grouping.
// Load and identity act in the accepting cycle; an advance walks back, sorts
// the tail and rotates over a registered-read memory, then strobes n results,
// one per cycle, or a single result with label 0 and no next when the shape is
// invalid (group size 0, fewer than two groups, or over MAX_N or 32 labels)
// one item at a time; busy stays high until the last result has been strobed
// the receiver cannot stall; reset restores identity order through valid bits
// ----------------------------------------------------------------------------
module next_equal_group_partition_top #(
  parameter int MAX_N = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  ngp_pkg::cmd_t cmd_i,
  output logic          busy_o,
  output logic          res_valid_o,
  output ngp_pkg::res_t res_o,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [1:0]    cfg_index_i,
  input  logic [5:0]    cfg_data_i
);

  typedef enum logic [23:0] {
    IDLE    = 24'h000001, CHK     = 24'h000002, A_RD1   = 24'h000004,
    A_CAP1  = 24'h000008, A_SCAN  = 24'h000010, A_CMP   = 24'h000020,
    A_DEC   = 24'h000040, B_TOP   = 24'h000080, B_TIP   = 24'h000100,
    B_CMP   = 24'h000200, S_RI    = 24'h000400, S_V     = 24'h000800,
    S_CMP   = 24'h001000, F_RD    = 24'h002000, F_CMP   = 24'h004000,
    R_INIT  = 24'h008000, R_REV   = 24'h010000, W_RA    = 24'h020000,
    W_RB    = 24'h040000, W_WA    = 24'h080000, W_WB    = 24'h100000,
    D_TRUE  = 24'h200000, D_FALSE = 24'h400000, EMIT    = 24'h800000
  } state_e;

  state_e state_q, state_d, ret_q, ret_d;

  logic [5:0] gsz_q, gcnt_q;

  // arrangement store, entries without a valid bit read as their own index
  logic [4:0] mem_q [ngp_pkg::STORE];
  logic [ngp_pkg::STORE-1:0] vld_q;
  logic       mem_we;
  logic [4:0] mem_waddr, mem_wdata, mem_raddr;
  logic       ident_clr;
  logic [4:0] rd_data_q, rd_addr_q;
  logic       rd_vld_q;
  logic [4:0] data;

  ngp_pkg::sidx_t hi1_q, hi1_d, hi2_q, hi2_d, low_q, low_d, k_q, k_d;
  ngp_pkg::sidx_t span_q, span_d, i_q, i_d, j_q, j_d, lo_q, lo_d, hi_q, hi_d;
  ngp_pkg::sidx_t first_q, first_d, mid_q, mid_d, last_q, last_d;
  ngp_pkg::sidx_t sa_q, sa_d, sb_q, sb_d;
  logic [4:0] v1_q, v1_d, tip_q, tip_d, sv_q, sv_d, swv_q, swv_d;
  logic [1:0] phase_q, phase_d;
  logic [5:0] n_q, n_d, nout_q, nout_d, cnt_q, cnt_d;
  logic       ok_q, ok_d, bad_q, bad_d;
  logic       pend_q, pend_d;
  logic [4:0] slot_q, slot_d;
  logic       lastf_q, lastf_d;

  logic [11:0]    prod;
  ngp_pkg::sidx_t nn, gg, pn, lst, md, fst;

  assign data = rd_vld_q ? rd_data_q : rd_addr_q;
  assign prod = gsz_q * gcnt_q;
  assign nn   = ngp_pkg::sidx_t'({2'b00, n_q});
  assign gg   = ngp_pkg::sidx_t'({2'b00, gsz_q});
  assign pn   = ngp_pkg::sidx_t'({2'b00, prod[5:0]});

  assign cfg_ready_o = 1'b1;
  assign busy_o      = (state_q != IDLE) || pend_q;
  assign res_valid_o = pend_q;
  assign res_o.slot     = slot_q;
  assign res_o.label    = bad_q ? 5'd0 : data;
  assign res_o.last     = lastf_q;
  assign res_o.has_next = ok_q;

  always_comb begin
    state_d = state_q; ret_d = ret_q;
    hi1_d = hi1_q; hi2_d = hi2_q; low_d = low_q; k_d = k_q; span_d = span_q;
    i_d = i_q; j_d = j_q; lo_d = lo_q; hi_d = hi_q;
    first_d = first_q; mid_d = mid_q; last_d = last_q; sa_d = sa_q; sb_d = sb_q;
    v1_d = v1_q; tip_d = tip_q; sv_d = sv_q; swv_d = swv_q; phase_d = phase_q;
    n_d = n_q; nout_d = nout_q; cnt_d = cnt_q; ok_d = ok_q; bad_d = bad_q;
    pend_d = 1'b0; slot_d = slot_q; lastf_d = lastf_q;
    mem_we = 1'b0; mem_waddr = '0; mem_wdata = '0; mem_raddr = '0;
    ident_clr = 1'b0;
    lst = '0; md = '0; fst = '0;
    case (state_q)
      IDLE: begin
        if (start_i && !pend_q) begin
          case (cmd_i.action)
            ngp_pkg::ACT_LOAD: begin
              mem_we = 1'b1; mem_waddr = cmd_i.position; mem_wdata = cmd_i.value;
            end
            ngp_pkg::ACT_IDENT: ident_clr = 1'b1;
            ngp_pkg::ACT_ADV:   state_d = CHK;
            default: ;
          endcase
        end
      end
      CHK: begin
        bad_d = 1'b0;
        if (gsz_q == 6'd0 || gcnt_q < 6'd2 || prod > 12'(MAX_N) || prod > 12'd32) begin
          bad_d = 1'b1; ok_d = 1'b0; nout_d = 6'd1; cnt_d = '0; state_d = EMIT;
        end else begin
          n_d = prod[5:0];
          hi1_d = pn - gg - 8'sd1;
          hi2_d = pn - 8'sd1;
          low_d = pn - gg - gg + 8'sd1;
          state_d = (gsz_q == 6'd1) ? D_FALSE : A_RD1;
        end
      end
      A_RD1: begin mem_raddr = hi1_q[4:0]; state_d = A_CAP1; end
      A_CAP1: begin v1_d = data; state_d = A_SCAN; end
      A_SCAN: begin
        if (hi2_q > hi1_q) begin
          mem_raddr = hi2_q[4:0]; state_d = A_CMP;
        end else begin
          state_d = A_DEC;
        end
      end
      A_CMP: begin
        if (data > v1_q) begin
          hi2_d = hi2_q - 8'sd1; state_d = A_SCAN;
        end else begin
          state_d = A_DEC;
        end
      end
      A_DEC: begin
        if (hi2_q + 8'sd1 < nn) begin
          sa_d = hi1_q; sb_d = hi2_q + 8'sd1; ret_d = D_TRUE; state_d = W_RA;
        end else begin
          state_d = B_TOP;
        end
      end
      B_TOP: begin
        if (hi1_q <= 8'sd0 || hi2_q < 8'sd0 || hi2_q >= nn) begin
          state_d = D_FALSE;
        end else begin
          mem_raddr = hi2_q[4:0]; state_d = B_TIP;
        end
      end
      B_TIP: begin tip_d = data; mem_raddr = hi1_q[4:0]; state_d = B_CMP; end
      B_CMP: begin
        if (hi1_q > low_q && hi1_q > 8'sd0 && tip_q < data) begin
          // step back and read the new entry under the walk
          hi1_d = hi1_q - 8'sd1;
          mem_raddr = 5'(hi1_q - 8'sd1);
        end else if (tip_q > data) begin
          v1_d = data;
          k_d = hi1_q + 8'sd1;
          span_d = low_q + gg - hi1_q - 8'sd1;
          i_d = hi1_q + 8'sd2;
          state_d = S_RI;
        end else begin
          hi1_d = hi1_q - 8'sd2; hi2_d = hi2_q - gg; low_d = low_q - gg;
          state_d = B_TOP;
        end
      end
      // insertion sort of the tail from k
      S_RI: begin
        if (i_q >= nn) begin
          state_d = F_RD;
        end else begin
          mem_raddr = i_q[4:0]; state_d = S_V;
        end
      end
      S_V: begin
        sv_d = data; j_d = i_q - 8'sd1; mem_raddr = 5'(i_q - 8'sd1); state_d = S_CMP;
      end
      S_CMP: begin
        mem_we = 1'b1; mem_waddr = 5'(j_q + 8'sd1);
        if (j_q >= k_q && data > sv_q) begin
          mem_wdata = data; j_d = j_q - 8'sd1; mem_raddr = 5'(j_q - 8'sd1);
        end else begin
          mem_wdata = sv_q; i_d = i_q + 8'sd1; state_d = S_RI;
        end
      end
      F_RD: begin
        if (k_q < nn - 8'sd1) begin
          mem_raddr = k_q[4:0]; state_d = F_CMP;
        end else if (k_q >= nn) begin
          state_d = D_FALSE;
        end else begin
          sa_d = k_q; sb_d = hi1_q; ret_d = R_INIT; state_d = W_RA;
        end
      end
      F_CMP: begin
        if (data < v1_q) begin
          k_d = k_q + 8'sd1; state_d = F_RD;
        end else begin
          sa_d = k_q; sb_d = hi1_q; ret_d = R_INIT; state_d = W_RA;
        end
      end
      // left rotation as three reversals
      R_INIT: begin
        lst = k_q + span_q;
        if (lst > nn) lst = nn;
        md = k_q + 8'sd1;
        if (md > lst) md = lst;
        fst = hi1_q + 8'sd1;
        if (fst < 8'sd0 || fst >= lst || md <= fst) begin
          state_d = D_TRUE;
        end else begin
          first_d = fst; mid_d = md; last_d = lst; phase_d = 2'd0;
          lo_d = fst; hi_d = md - 8'sd1; state_d = R_REV;
        end
      end
      R_REV: begin
        if (lo_q < hi_q) begin
          sa_d = lo_q; sb_d = hi_q; lo_d = lo_q + 8'sd1; hi_d = hi_q - 8'sd1;
          ret_d = R_REV; state_d = W_RA;
        end else begin
          case (phase_q)
            2'd0: begin phase_d = 2'd1; lo_d = mid_q; hi_d = last_q - 8'sd1; end
            2'd1: begin phase_d = 2'd2; lo_d = first_q; hi_d = last_q - 8'sd1; end
            default: state_d = D_TRUE;
          endcase
        end
      end
      W_RA: begin mem_raddr = sa_q[4:0]; state_d = W_RB; end
      W_RB: begin swv_d = data; mem_raddr = sb_q[4:0]; state_d = W_WA; end
      W_WA: begin
        mem_we = 1'b1; mem_waddr = sa_q[4:0]; mem_wdata = data; state_d = W_WB;
      end
      W_WB: begin
        mem_we = 1'b1; mem_waddr = sb_q[4:0]; mem_wdata = swv_q; state_d = ret_q;
      end
      D_TRUE: begin ok_d = 1'b1; nout_d = n_q; cnt_d = '0; state_d = EMIT; end
      D_FALSE: begin ok_d = 1'b0; nout_d = n_q; cnt_d = '0; state_d = EMIT; end
      EMIT: begin
        mem_raddr = cnt_q[4:0];
        pend_d = 1'b1; slot_d = cnt_q[4:0];
        lastf_d = (cnt_q == nout_q - 6'd1);
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == nout_q - 6'd1) state_d = IDLE;
      end
      default: state_d = IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= IDLE; ret_q <= IDLE;
      gsz_q <= 6'd2; gcnt_q <= 6'd2;
      vld_q <= '0; pend_q <= 1'b0;
    end else begin
      state_q <= state_d; ret_q <= ret_d; pend_q <= pend_d;
      if (cfg_valid_i && cfg_index_i == ngp_pkg::CFG_GSIZE) gsz_q <= cfg_data_i;
      if (cfg_valid_i && cfg_index_i == ngp_pkg::CFG_GCOUNT) gcnt_q <= cfg_data_i;
      if (ident_clr) vld_q <= '0;
      else if (mem_we) vld_q[mem_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= mem_wdata;
    rd_data_q <= mem_q[mem_raddr];
    rd_vld_q  <= vld_q[mem_raddr];
    rd_addr_q <= mem_raddr;
  end

  always_ff @(posedge clk_i) begin
    hi1_q <= hi1_d; hi2_q <= hi2_d; low_q <= low_d; k_q <= k_d; span_q <= span_d;
    i_q <= i_d; j_q <= j_d; lo_q <= lo_d; hi_q <= hi_d;
    first_q <= first_d; mid_q <= mid_d; last_q <= last_d; sa_q <= sa_d; sb_q <= sb_d;
    v1_q <= v1_d; tip_q <= tip_d; sv_q <= sv_d; swv_q <= swv_d; phase_q <= phase_d;
    n_q <= n_d; nout_q <= nout_d; cnt_q <= cnt_d; ok_q <= ok_d; bad_q <= bad_d;
    slot_q <= slot_d; lastf_q <= lastf_d;
  end

endmodule

### tb/tb_next_equal_group_partition_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_next_equal_group_partition_top
// Drives load, identity and advance words into the grouping stepper under
// several group shapes, predicts every emitted arrangement and flag, and
// checks each strobed result in order against the predicted stream.
// ----------------------------------------------------------------------------
module tb_next_equal_group_partition_top;

  localparam int MAX_N = 32;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          start_i = 1'b0;
  ngp_pkg::cmd_t cmd_i = '0;
  logic          busy_o;
  logic          res_valid_o;
  ngp_pkg::res_t res_o;
  logic          cfg_valid_i = 1'b0;
  logic          cfg_ready_o;
  logic [1:0]    cfg_index_i = '0;
  logic [5:0]    cfg_data_i = '0;

  next_equal_group_partition_top #(.MAX_N(MAX_N)) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .cmd_i      (cmd_i),
    .busy_o     (busy_o),
    .res_valid_o(res_valid_o),
    .res_o      (res_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predicted block state
  logic [5:0]    gsize_q;
  logic [5:0]    gcount_q;
  logic [4:0]    arr_q [ngp_pkg::STORE];
  ngp_pkg::res_t grouping_q [$];

  int err_cnt;
  int burst_left;

  function automatic void swap_entries(int a, int b);
    logic [4:0] t;
    t = arr_q[a];
    arr_q[a] = arr_q[b];
    arr_q[b] = t;
  endfunction

  function automatic void sort_from(int from, int n);
    logic [4:0] v;
    int j;
    for (int i = from + 1; i < n; i++) begin
      v = arr_q[i];
      j = i - 1;
      while (j >= from && arr_q[j] > v) begin
        arr_q[j + 1] = arr_q[j];
        j--;
      end
      arr_q[j + 1] = v;
    end
  endfunction

  // left rotation of [first,last) bringing mid to the front, clamped at n
  function automatic void rotate_left(int first, int mid, int last, int n);
    logic [4:0] tmp [ngp_pkg::STORE];
    int len, sh;
    if (last > n) last = n;
    if (mid > last) mid = last;
    if (first < 0 || first >= last || mid <= first) return;
    len = last - first;
    sh = mid - first;
    for (int i = 0; i < len; i++) tmp[i] = arr_q[first + (i + sh) % len];
    for (int i = 0; i < len; i++) arr_q[first + i] = tmp[i];
  endfunction

  function automatic bit next_grouping(int g, int r, int n);
    int hi1, hi2, low, k, span;
    logic [4:0] tip;
    hi1 = (r - 1) * g - 1;
    hi2 = n - 1;
    low = (r - 2) * g + 1;
    if (g == 1) return 1'b0;
    while (hi2 > hi1 && arr_q[hi2] > arr_q[hi1]) hi2--;
    if (hi2 + 1 < n) begin
      swap_entries(hi1, hi2 + 1);
      return 1'b1;
    end
    while (hi1 > 0) begin
      if (hi2 < 0 || hi2 >= n) return 1'b0;
      tip = arr_q[hi2];
      while (hi1 > low && hi1 > 0 && tip < arr_q[hi1]) hi1--;
      if (tip > arr_q[hi1]) begin
        k = hi1 + 1;
        span = low + g - k;
        sort_from(k, n);
        while (k < n - 1 && arr_q[k] < arr_q[hi1]) k++;
        if (k >= n) return 1'b0;
        swap_entries(k, hi1);
        rotate_left(hi1 + 1, k + 1, k + span, n);
        return 1'b1;
      end
      hi1 -= 2;
      hi2 -= g;
      low -= g;
    end
    return 1'b0;
  endfunction

  function automatic void set_identity();
    for (int i = 0; i < ngp_pkg::STORE; i++) arr_q[i] = 5'(i);
  endfunction

  function automatic void apply_word(ngp_pkg::cmd_t c);
    int n;
    bit ok;
    ngp_pkg::res_t r;
    case (c.action)
      ngp_pkg::ACT_LOAD:  arr_q[c.position] = c.value;
      ngp_pkg::ACT_IDENT: set_identity();
      ngp_pkg::ACT_ADV: begin
        n = int'(gsize_q) * int'(gcount_q);
        if (gsize_q < 1 || gcount_q < 2 || n > MAX_N || n > ngp_pkg::STORE) begin
          r = '{slot: 5'd0, label: 5'd0, last: 1'b1, has_next: 1'b0};
          grouping_q.insert(grouping_q.size(), r);
        end else begin
          ok = next_grouping(int'(gsize_q), int'(gcount_q), n);
          for (int k = 0; k < n; k++) begin
            r.slot = 5'(k);
            r.label = arr_q[k];
            r.last = (k == n - 1);
            r.has_next = ok;
            grouping_q.insert(grouping_q.size(), r);
          end
        end
      end
      default: ;
    endcase
  endfunction

  // result checker
  always @(posedge clk_i) begin
    ngp_pkg::res_t e;
    if (rst_ni && res_valid_o) begin
      if (grouping_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) $display("unexpected result word %p", res_o);
      end else begin
        e = grouping_q.pop_front();
        if (res_o.slot !== e.slot || res_o.label !== e.label ||
            res_o.last !== e.last || res_o.has_next !== e.has_next) begin
          err_cnt++;
          if (err_cnt <= 10) $display("mismatch: expected %p, got %p", e, res_o);
        end
      end
    end
  end

  // start stays high across a burst; callers that pause go through settle
  task automatic send_word(ngp_pkg::cmd_t c);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      gap = $urandom_range(0, 5);
      repeat (gap) begin
        @(negedge clk_i);
        start_i <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk_i);
    start_i <= 1'b1;
    cmd_i <= c;
    do @(posedge clk_i); while (busy_o);
    apply_word(c);
  endtask

  task automatic settle();
    @(negedge clk_i);
    start_i <= 1'b0;
    burst_left = 0;
    while (grouping_q.size() != 0) @(posedge clk_i);
    do @(posedge clk_i); while (busy_o);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [5:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == ngp_pkg::CFG_GSIZE) gsize_q = data;
    else if (idx == ngp_pkg::CFG_GCOUNT) gcount_q = data;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_shape(logic [5:0] gs, logic [5:0] gc);
    settle();
    write_reg(ngp_pkg::CFG_GSIZE, gs);
    write_reg(ngp_pkg::CFG_GCOUNT, gc);
  endtask

  function automatic ngp_pkg::cmd_t mk(logic [1:0] a, logic [4:0] p = '0,
                                       logic [4:0] v = '0);
    ngp_pkg::cmd_t c;
    c.action = a;
    c.position = p;
    c.value = v;
    return c;
  endfunction

  // reset shape 2x2: three groupings, then exhausted
  task automatic test_default_walk();
    repeat (4) send_word(mk(ngp_pkg::ACT_ADV));
    send_word(mk(ngp_pkg::ACT_IDENT));
    send_word(mk(2'd3, 5'd31, 5'd31));
    send_word(mk(ngp_pkg::ACT_ADV));
    settle();
  endtask

  task automatic test_load_extremes();
    send_word(mk(ngp_pkg::ACT_LOAD, 5'd31, 5'd31));
    send_word(mk(ngp_pkg::ACT_LOAD, 5'd0, 5'd31));
    send_word(mk(ngp_pkg::ACT_LOAD, 5'd3, 5'd0));
    send_word(mk(ngp_pkg::ACT_ADV));
    send_word(mk(ngp_pkg::ACT_LOAD, 5'd1, 5'd1));
    send_word(mk(ngp_pkg::ACT_ADV));
    send_word(mk(ngp_pkg::ACT_IDENT));
    settle();
  endtask

  task automatic test_bad_config();
    set_shape(6'd0, 6'd2);
    send_word(mk(ngp_pkg::ACT_ADV));
    set_shape(6'd2, 6'd1);
    send_word(mk(ngp_pkg::ACT_ADV));
    set_shape(6'd63, 6'd63);
    send_word(mk(ngp_pkg::ACT_ADV));
    set_shape(6'd3, 6'd11);
    send_word(mk(ngp_pkg::ACT_ADV));
    set_shape(6'd2, 6'd0);
    send_word(mk(ngp_pkg::ACT_ADV));
    settle();
  endtask

  task automatic test_single_label_groups();
    set_shape(6'd1, 6'd32);
    send_word(mk(ngp_pkg::ACT_IDENT));
    send_word(mk(ngp_pkg::ACT_ADV));
    set_shape(6'd16, 6'd2);
    send_word(mk(ngp_pkg::ACT_ADV));
    set_shape(6'd2, 6'd16);
    send_word(mk(ngp_pkg::ACT_ADV));
    settle();
  endtask

  // mostly clean walks from identity, some loads that break the form
  task automatic test_random_walks();
    logic [5:0] shapes [8][2] = '{'{6'd2, 6'd2}, '{6'd2, 6'd3}, '{6'd3, 6'd2},
                                  '{6'd2, 6'd4}, '{6'd3, 6'd3}, '{6'd4, 6'd4},
                                  '{6'd2, 6'd16}, '{6'd8, 6'd4}};
    int s, steps;
    for (int ph = 0; ph < 12; ph++) begin
      s = (ph < 8) ? ph : $urandom_range(0, 7);
      set_shape(shapes[s][0], shapes[s][1]);
      send_word(mk(ngp_pkg::ACT_IDENT));
      steps = $urandom_range(10, 20);
      for (int i = 0; i < steps; i++) begin
        case ($urandom_range(0, 9))
          0: send_word(mk(ngp_pkg::ACT_LOAD, 5'($urandom), 5'($urandom)));
          1: send_word(mk(2'($urandom_range(1, 3)), 5'($urandom), 5'($urandom)));
          default: send_word(mk(ngp_pkg::ACT_ADV, 5'($urandom), 5'($urandom)));
        endcase
      end
    end
    settle();
  endtask

  initial begin
    err_cnt = 0;
    burst_left = 0;
    gsize_q = 6'd2;
    gcount_q = 6'd2;
    set_identity();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_default_walk();
    test_load_extremes();
    test_bad_config();
    test_single_label_groups();
    test_random_walks();
    repeat (50) @(posedge clk_i);
    if (err_cnt == 0 && grouping_q.size() == 0) begin
      $display("tb_next_equal_group_partition_top: done, clean");
    end else begin
      $display("tb_next_equal_group_partition_top: done, errors");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("tb_next_equal_group_partition_top: done, errors");
    $finish;
  end

endmodule

### files.f
hdl/ngp_pkg.sv
hdl/next_equal_group_partition_top.sv
tb/tb_next_equal_group_partition_top.sv
